// File: design/pfba_pkg.sv
package pfba_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BIT_W   = 5;
  localparam int unsigned FRAME_W = 12;
  localparam int unsigned CFG_W   = 8;

  localparam logic [WORD_W-1:0] WORD_FULL = 32'hFFFF_FFFF;
  localparam logic [CFG_W-1:0]  BW_RESET  = 8'd128;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOCHANGE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [1:0] REG_BITMAP_WORDS = 2'd0;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               writable;
    logic               user;
    logic [1:0]         status;
  } res_t;

  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: design/page_frame_bitmap_allocator.sv
// Channel | Dir | Beat fields                                             | Handshake
// in      | in  | operation, entry_frame, kernel_page, write_allowed      | in_valid/in_ready
// out     | out | frame_out, present_set, writable_out, user_out, status  | out_valid/out_ready
// cfg     | in  | bitmap_words at byte address 0                          | APB, pready high
//
// Allocate: one bitmap word read per cycle through the memory read port, scanning
//   up to min(bitmap_words, MAX_WORDS) words between accept and result.
// Free: read-modify-write of one word when the frame is in range. No-change requests skip the bitmap.
// After reset a clearing pass writes MAX_WORDS words, one a cycle, before in_ready.
// One request at a time; a result waiting on out_ready holds the next one in its last step.
module page_frame_bitmap_allocator #(
  parameter int unsigned MAX_WORDS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [pfba_pkg::FRAME_W-1:0] entry_frame_i,
  input  logic        kernel_page_i,
  input  logic        write_allowed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [pfba_pkg::FRAME_W-1:0] frame_out_o,
  output logic        present_set_o,
  output logic        writable_out_o,
  output logic        user_out_o,
  output logic [1:0]  status_o
);
  import pfba_pkg::*;

  localparam int unsigned AW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned CW   = $clog2(MAX_WORDS + 1);
  localparam int unsigned LIMW = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned FFW  = AW + BIT_W;
  localparam int unsigned EIW  = FRAME_W - BIT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state_q;
  logic [CFG_W-1:0]   bw_q;
  logic [AW-1:0]      clr_q;
  logic [LIMW-1:0]    scan_q, lim_q, lim_d;
  logic               pend_q;
  logic [AW-1:0]      pend_idx_q;
  logic [AW-1:0]      fr_idx_q;
  logic [FRAME_W-1:0] ent_q;
  logic               kern_q, wr_flag_q;
  res_t               res_q;
  logic               out_valid_q;
  res_t               out_q;

  logic [WORD_W-1:0]  mem_q [MAX_WORDS];
  logic [WORD_W-1:0]  rdata_q;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [WORD_W-1:0]  wr_data;

  logic               in_acc, cfg_wr, found, issue, fr_in_range, out_load;
  logic [BIT_W-1:0]   zbit;
  logic [FFW-1:0]     f_full;
  logic [EIW-1:0]     ent_word;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr == REG_BITMAP_WORDS);
  assign prdata   = (paddr == REG_BITMAP_WORDS) ? {{(32-CFG_W){1'b0}}, bw_q} : '0;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign ent_word    = entry_frame_i[FRAME_W-1:BIT_W];
  assign fr_in_range = (32'(ent_word) < MAX_WORDS);
  assign lim_d       = (32'(bw_q) > MAX_WORDS) ? LIMW'(MAX_WORDS) : LIMW'(bw_q);

  assign found  = (state_q == S_SCAN) && pend_q && (rdata_q != WORD_FULL);
  assign issue  = (state_q == S_SCAN) && (scan_q < lim_q) && !found;
  assign zbit   = first_zero(rdata_q);
  assign f_full = {pend_idx_q, zbit};

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(scan_q);
    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_data = '0;
    unique case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        rd_en   = in_acc && (operation_i == OP_FREE) && fr_in_range;
        rd_addr = AW'(ent_word);
      end
      S_SCAN: begin
        rd_en   = issue;
        wr_en   = found;
        wr_addr = pend_idx_q;
        wr_data = rdata_q | (WORD_W'(1) << zbit);
      end
      S_FREE: begin
        wr_en   = 1'b1;
        wr_addr = fr_idx_q;
        wr_data = rdata_q & ~(WORD_W'(1) << ent_q[BIT_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      bw_q        <= BW_RESET;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) bw_q <= pwdata[CFG_W-1:0];
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAX_WORDS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            scan_q <= '0;
            pend_q <= 1'b0;
            if (entry_frame_i != '0) begin
              state_q <= (operation_i == OP_FREE && fr_in_range) ? S_FREE : S_DONE;
            end else begin
              state_q <= (operation_i == OP_ALLOC) ? S_SCAN : S_DONE;
            end
          end
        end
        S_SCAN: begin
          pend_q <= issue;
          if (issue) scan_q <= scan_q + LIMW'(1);
          if (found || (!pend_q && !issue)) state_q <= S_DONE;
        end
        S_FREE: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ent_q          <= entry_frame_i;
      kern_q         <= kernel_page_i;
      wr_flag_q      <= write_allowed_i;
      fr_idx_q       <= AW'(ent_word);
      lim_q          <= lim_d;
      res_q.present  <= 1'b0;
      res_q.writable <= 1'b0;
      res_q.user     <= 1'b0;
      if (operation_i == OP_ALLOC) begin
        res_q.frame  <= entry_frame_i;
        res_q.status <= (entry_frame_i != '0) ? ST_NOCHANGE : ST_FULL;
      end else begin
        res_q.frame  <= '0;
        res_q.status <= (entry_frame_i != '0) ? ST_DONE : ST_NOCHANGE;
      end
    end
    if (issue) pend_idx_q <= AW'(scan_q);
    if (found) begin
      res_q.frame    <= FRAME_W'(f_full);
      res_q.present  <= 1'b1;
      res_q.writable <= wr_flag_q;
      res_q.user     <= !kern_q;
      res_q.status   <= ST_DONE;
    end
    if (out_load) out_q <= res_q;
  end

  assign out_valid_o    = out_valid_q;
  assign frame_out_o    = out_q.frame;
  assign present_set_o  = out_q.present;
  assign writable_out_o = out_q.writable;
  assign user_out_o     = out_q.user;
  assign status_o       = out_q.status;

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> scan_q <= lim_q)
    else $error("scan pointer passed word limit");

  a_present_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && present_set_o |-> status_o == ST_DONE)
    else $error("present set without done status");

  a_flags_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_DONE) |-> !present_set_o && !writable_out_o && !user_out_o)
    else $error("entry flags set on a no-change or full result");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !wr_en)
    else $error("bitmap written while idle");

endmodule
